@@ rtl/core/cgms_pkg.sv @@
package cgms_pkg;

   // grid geometry
   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;

   localparam int COL_W  = $clog2(GRID_WIDTH);
   localparam int ROW_W  = $clog2(GRID_HEIGHT);
   // one address bit selects the buffer half
   localparam int ADDR_W = ROW_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   // fixed field widths of the channels
   localparam int OP_W      = 2;
   localparam int POS_W     = 6;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 1;

   // opcodes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_COUNT     = 1'd1;

   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 4'd5;
   localparam logic [CFG_W-1:0] PASSES_RESET    = 4'd5;

   // response payload select
   localparam logic [1:0] RSP_NONE = 2'd0;
   localparam logic [1:0] RSP_READ = 2'd1;
   localparam logic [1:0] RSP_RUN  = 2'd2;

   typedef logic [GRID_WIDTH-1:0] row_type;

   // controller to datapath commands
   typedef struct packed {
      logic             host_wr;
      logic             host_rd;
      logic             scan_rd;
      logic [ROW_W-1:0] scan_row;
      logic             proc_vld;
      logic [ROW_W-1:0] proc_row;
      logic             tail;
      logic             flip;
      logic             rsp_load;
      logic [1:0]       rsp_sel;
   } cmd_type;

   // one smoothing step over a whole row, border columns kept
   function automatic row_type smooth_row(input row_type above, input row_type mid,
                                          input row_type below,
                                          input logic [CFG_W-1:0] thr);
      row_type    res;
      logic [3:0] cnt;
      res = mid;
      cnt = '0;
      for (int c = 1; c < GRID_WIDTH - 1; c++) begin
         cnt = 4'(above[c-1]) + 4'(above[c]) + 4'(above[c+1])
             + 4'(mid[c-1])   + 4'(mid[c])   + 4'(mid[c+1])
             + 4'(below[c-1]) + 4'(below[c]) + 4'(below[c+1]);
         res[c] = (cnt >= thr);
      end
      return res;
   endfunction

endpackage

@@ rtl/core/cgms_ifs.sv @@
interface cgms_req_if;
   logic                         valid;
   logic                         ready;
   logic [cgms_pkg::OP_W-1:0]    op;
   logic [cgms_pkg::POS_W-1:0]   col;
   logic [cgms_pkg::POS_W-1:0]   row;
   logic                         wall_in;
   modport source (output valid, op, col, row, wall_in, input ready);
   modport sink   (input valid, op, col, row, wall_in, output ready);
endinterface

interface cgms_rsp_if;
   logic valid;
   logic ready;
   logic wall_out;
   logic run_done;
   modport source (output valid, wall_out, run_done, input ready);
   modport sink   (input valid, wall_out, run_done, output ready);
endinterface

interface cgms_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cgms_pkg::CSR_IDX_W-1:0]   index;
   logic [cgms_pkg::CFG_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/cgms_dp.sv @@
module cgms_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  cgms_pkg::cmd_type              cmd,
   input  logic [cgms_pkg::POS_W-1:0]     req_col,
   input  logic [cgms_pkg::POS_W-1:0]     req_row,
   input  logic                           req_wall_in,
   input  logic                           csr_we,
   input  logic [cgms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cgms_pkg::CFG_W-1:0]     csr_data,
   output logic [cgms_pkg::CFG_W-1:0]     pass_count,
   output logic                           wall_out,
   output logic                           run_done
);

   // both grid buffers, one row per word
   cgms_pkg::row_type mem [cgms_pkg::MEM_DEPTH];

   cgms_pkg::row_type rd_data_ff, above_ff, above_in, mid_ff, mid_in;
   logic                          bank_ff, bank_in;
   logic [cgms_pkg::CFG_W-1:0]    threshold_ff, threshold_in, pass_count_ff, pass_count_in;
   logic [cgms_pkg::COL_W-1:0]    col_ff, col_in;
   logic                          on_grid_ff, on_grid_in;
   logic                          wall_out_ff, wall_out_in, run_done_ff, run_done_in;

   logic                          on_grid_now;
   logic [cgms_pkg::COL_W-1:0]    col_idx;
   logic [cgms_pkg::ROW_W-1:0]    row_idx;
   logic                          rd_en, wr_en;
   logic [cgms_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
   cgms_pkg::row_type             wr_data, wr_mask;

   assign on_grid_now = (int'(req_col) < cgms_pkg::GRID_WIDTH)
                     && (int'(req_row) < cgms_pkg::GRID_HEIGHT);
   assign col_idx = cgms_pkg::COL_W'(req_col);
   assign row_idx = cgms_pkg::ROW_W'(req_row);

   // read port
   always_comb begin
      rd_en   = cmd.host_rd || cmd.scan_rd;
      rd_addr = cmd.host_rd ? {bank_ff, row_idx} : {bank_ff, cmd.scan_row};
   end

   // write port: host cell writes go to the live half, pass rows to the other
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {~bank_ff, cmd.proc_row};
      wr_data = rd_data_ff;
      wr_mask = '1;
      if (cmd.host_wr) begin
         wr_en   = on_grid_now;
         wr_addr = {bank_ff, row_idx};
         wr_data = {cgms_pkg::GRID_WIDTH{req_wall_in}};
         wr_mask = cgms_pkg::row_type'(1) << col_idx;
      end else if (cmd.tail) begin
         wr_en   = 1'b1;
         wr_addr = {~bank_ff, cgms_pkg::ROW_W'(cgms_pkg::GRID_HEIGHT - 1)};
         wr_data = mid_ff;
      end else if (cmd.proc_vld) begin
         if (cmd.proc_row == '0) begin
            wr_en = 1'b1;
         end else if (cmd.proc_row >= cgms_pkg::ROW_W'(2)) begin
            wr_en   = 1'b1;
            wr_addr = {~bank_ff, cgms_pkg::ROW_W'(cmd.proc_row - 1'b1)};
            wr_data = cgms_pkg::smooth_row(above_ff, mid_ff, rd_data_ff, threshold_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < cgms_pkg::GRID_WIDTH; i++) begin
            if (wr_mask[i]) begin
               mem[wr_addr][i] <= wr_data[i];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // row window and response payload
   always_comb begin
      above_in    = above_ff;
      mid_in      = mid_ff;
      col_in      = col_ff;
      on_grid_in  = on_grid_ff;
      wall_out_in = wall_out_ff;
      run_done_in = run_done_ff;
      if (cmd.proc_vld) begin
         above_in = mid_ff;
         mid_in   = rd_data_ff;
      end
      if (cmd.host_rd) begin
         col_in     = col_idx;
         on_grid_in = on_grid_now;
      end
      if (cmd.rsp_load) begin
         wall_out_in = (cmd.rsp_sel == cgms_pkg::RSP_READ) && on_grid_ff && rd_data_ff[col_ff];
         run_done_in = (cmd.rsp_sel == cgms_pkg::RSP_RUN);
      end
   end

   always_ff @(posedge clock) begin
      above_ff    <= above_in;
      mid_ff      <= mid_in;
      col_ff      <= col_in;
      on_grid_ff  <= on_grid_in;
      wall_out_ff <= wall_out_in;
      run_done_ff <= run_done_in;
   end

   // live-half select and config registers
   always_comb begin
      bank_in       = cmd.flip ? ~bank_ff : bank_ff;
      threshold_in  = threshold_ff;
      pass_count_in = pass_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            cgms_pkg::CSR_WALL_THRESHOLD: threshold_in  = csr_data;
            cgms_pkg::CSR_PASS_COUNT:     pass_count_in = csr_data;
            default:                      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff       <= 1'b0;
         threshold_ff  <= cgms_pkg::THRESHOLD_RESET;
         pass_count_ff <= cgms_pkg::PASSES_RESET;
      end else begin
         bank_ff       <= bank_in;
         threshold_ff  <= threshold_in;
         pass_count_ff <= pass_count_in;
      end
   end

   assign pass_count = pass_count_ff;
   assign wall_out   = wall_out_ff;
   assign run_done   = run_done_ff;

endmodule

@@ rtl/core/cgms_ctrl.sv @@
module cgms_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [cgms_pkg::OP_W-1:0]   req_op,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [cgms_pkg::CFG_W-1:0]  pass_count,
   output cgms_pkg::cmd_type           cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_PASS  = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;

   localparam logic [cgms_pkg::ROW_W-1:0] LAST_ROW = cgms_pkg::ROW_W'(cgms_pkg::GRID_HEIGHT - 1);

   logic [2:0]                   state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cgms_pkg::CFG_W-1:0]   passes_ff, passes_in;
   logic [cgms_pkg::ROW_W-1:0]   scan_row_ff, scan_row_in, proc_row_ff, proc_row_in;
   logic                         proc_vld_ff, proc_vld_in;
   logic                         slot_free, accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      passes_in    = passes_ff;
      scan_row_in  = scan_row_ff;
      proc_vld_in  = 1'b0;
      proc_row_in  = proc_row_ff;
      cmd          = '0;
      cmd.scan_row = scan_row_ff;
      cmd.proc_vld = proc_vld_ff;
      cmd.proc_row = proc_row_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  cgms_pkg::OP_WRITE: begin
                     cmd.host_wr  = 1'b1;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = cgms_pkg::RSP_NONE;
                  end
                  cgms_pkg::OP_READ: begin
                     cmd.host_rd = 1'b1;
                     state_in    = S_READ;
                  end
                  cgms_pkg::OP_RUN: begin
                     if (pass_count == '0) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_sel  = cgms_pkg::RSP_RUN;
                     end else begin
                        passes_in   = pass_count;
                        scan_row_in = '0;
                        state_in    = S_PASS;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = cgms_pkg::RSP_NONE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = cgms_pkg::RSP_READ;
            state_in     = S_IDLE;
         end
         S_PASS: begin
            cmd.scan_rd = 1'b1;
            proc_vld_in = 1'b1;
            proc_row_in = scan_row_ff;
            scan_row_in = cgms_pkg::ROW_W'(scan_row_ff + 1'b1);
            if (scan_row_ff == LAST_ROW) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_TAIL;
         end
         S_TAIL: begin
            cmd.tail    = 1'b1;
            cmd.flip    = 1'b1;
            passes_in   = passes_ff - 1'b1;
            scan_row_in = '0;
            if (passes_ff == cgms_pkg::CFG_W'(1)) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = cgms_pkg::RSP_RUN;
               state_in     = S_IDLE;
            end else begin
               state_in = S_PASS;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         passes_ff    <= '0;
         scan_row_ff  <= '0;
         proc_vld_ff  <= 1'b0;
         proc_row_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         passes_ff    <= passes_in;
         scan_row_ff  <= scan_row_in;
         proc_vld_ff  <= proc_vld_in;
         proc_row_ff  <= proc_row_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_pass_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PASS || state_ff == S_FLUSH || state_ff == S_TAIL) |-> passes_ff != '0)
      else $error("pass counter empty during a run");

   a_flush_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> proc_vld_ff && proc_row_ff == LAST_ROW)
      else $error("flush without last row in flight");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> slot_free)
      else $error("response overwritten");

   a_tail_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TAIL |=> state_ff == S_PASS || state_ff == S_IDLE)
      else $error("bad state after pass tail");

endmodule

@@ rtl/core/cave_grid_majority_smoother.sv @@
// write beat: response registered in the cycle after accept, next item taken once the response slot is free
// read beat: the row read of the grid memory is registered, then S_READ loads the registered response
// run beat: pass_count passes; each pass streams one row per cycle
//   through the single memory read port, plus one flush and one tail row write
// reset (synchronous, active high) clears control, threshold 5 and pass count 5;
//   grid contents stay undefined until the host writes every cell
module cave_grid_majority_smoother (
   input  logic     clock,
   input  logic     reset,
   cgms_req_if.sink   req_ch,
   cgms_rsp_if.source rsp_ch,
   cgms_csr_if.sink   csr_ch
);

   cgms_pkg::cmd_type             cmd;
   logic [cgms_pkg::CFG_W-1:0]    pass_count;
   logic                          csr_we;

   // config writes are always taken; the host must write only while the block is idle, the block does not enforce it
   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid;

   // sequencer: host beat decode, pass and row counters, response valid
   cgms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_op     (req_ch.op),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .pass_count (pass_count),
      .cmd        (cmd)
   );

   // grid memory (two halves, ping-pong), three-row window, smoothing logic,
   // config registers and response payload
   cgms_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_col     (req_ch.col),
      .req_row     (req_ch.row),
      .req_wall_in (req_ch.wall_in),
      .csr_we      (csr_we),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .pass_count  (pass_count),
      .wall_out    (rsp_ch.wall_out),
      .run_done    (rsp_ch.run_done)
   );

endmodule
